// File: rtl/euler_to_quaternion_top_defines.svh
// assertion macros for the euler to quaternion block
// included by the top level; needs clk and arst_n in scope
`ifndef EULER_TO_QUATERNION_TOP_DEFINES_SVH
`define EULER_TO_QUATERNION_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define E2Q_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define E2Q_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/e2q_pkg.sv
// types, constants and arithmetic helpers for the euler to quaternion block
// no dependencies; used by every rtl module of the block
package e2q_pkg;

	localparam int unsigned ONE_Q14 = 16384;
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam int unsigned TAYLOR_TERMS = 10;
	localparam logic [8:0] TAYLOR_DIV [1:TAYLOR_TERMS] =
		'{9'd6, 9'd20, 9'd42, 9'd72, 9'd110, 9'd156, 9'd210, 9'd272, 9'd342, 9'd420};

	typedef struct packed {
		logic signed [15:0] roll_angle;
		logic signed [15:0] pitch_angle;
		logic signed [15:0] yaw_angle;
	} angles_t;

	typedef struct packed {
		logic signed [15:0] quat_w;
		logic signed [15:0] quat_x;
		logic signed [15:0] quat_y;
		logic signed [15:0] quat_z;
	} quat_t;

	// sine and cosine of one half angle, magnitude and sign
	typedef struct packed {
		logic        sin_neg;
		logic [14:0] sin_mag;
		logic        cos_neg;
		logic [14:0] cos_mag;
	} trig_t;

	// second-level products, two per quaternion term
	typedef struct packed {
		logic signed [15:0] w_a;
		logic signed [15:0] w_b;
		logic signed [15:0] x_a;
		logic signed [15:0] x_b;
		logic signed [15:0] y_a;
		logic signed [15:0] y_b;
		logic signed [15:0] z_a;
		logic signed [15:0] z_b;
	} prod_t;

	// quarter-wave sine entry, q14, elaboration only
	function automatic logic [14:0] quarter_sine(input int unsigned j, input int unsigned tb);
		logic [63:0]        x;
		logic [63:0]        x2;
		logic [63:0]        term;
		logic signed [63:0] sum;
		logic [63:0]        rnd;
		int unsigned        k;
		x = (64'd2 * PI_Q30 * 64'(j) + (64'd1 << (tb - 1))) >> tb;
		x2 = (x * x) >> 30;
		term = x;
		sum = signed'(x);
		for (k = 1; k <= TAYLOR_TERMS; k++) begin
			term = (term * x2) >> 30;
			term = term / 64'(TAYLOR_DIV[k]);
			if (k[0])
				sum = sum - signed'(term);
			else
				sum = sum + signed'(term);
		end
		if (sum < 0)
			sum = 64'sd0;
		rnd = (64'(sum) + 64'd32768) >> 16;
		return rnd[14:0];
	endfunction

	function automatic logic signed [15:0] to_q14(input logic neg, input logic [14:0] mag);
		logic signed [15:0] v;
		v = signed'({1'b0, mag});
		return neg ? -v : v;
	endfunction

	// q2.14 product, round half up
	function automatic logic signed [15:0] mul14(input logic signed [15:0] a,
		input logic signed [15:0] b);
		logic signed [31:0] p;
		p = 32'(a * b) + 32'sd8192;
		return p[29:14];
	endfunction

	function automatic logic signed [15:0] sat_q14(input logic signed [16:0] v);
		if (v > 17'sd16384)
			return 16'sd16384;
		else if (v < -17'sd16384)
			return -16'sd16384;
		else
			return v[15:0];
	endfunction

endpackage

// File: rtl/e2q_trig.sv
// half-angle sine and cosine lookup from a quarter-wave rom
// depends on e2q_pkg; rom contents are built at elaboration
module e2q_trig #(
	parameter int unsigned TABLE_BITS = 10
) (
	input  logic                 clk,
	input  logic signed [15:0]   angle,
	output e2q_pkg::trig_t       trig_s1
);

	localparam int unsigned QUARTER = 1 << (TABLE_BITS - 2);
	localparam int unsigned QDEPTH  = QUARTER + 1;
	localparam int unsigned AW      = TABLE_BITS - 1;
	localparam logic [AW-1:0] QUARTER_A = AW'(QUARTER);

	logic [14:0] rom_mem [QDEPTH];

	for (genvar j = 0; j < QDEPTH; j++) begin : g_rom
		localparam logic [14:0] ENTRY = e2q_pkg::quarter_sine(j, TABLE_BITS);
		assign rom_mem[j] = ENTRY;
	end

	logic signed [15:0]    half;
	logic [TABLE_BITS-1:0] idx;
	logic [1:0]            sin_quad;
	logic [1:0]            cos_quad;
	logic [AW-1:0]         r_ext;
	logic [AW-1:0]         sin_addr;
	logic [AW-1:0]         cos_addr;

	always_comb begin
		// halve toward zero
		half = (angle + signed'({15'd0, angle[15]})) >>> 1;
		idx = half[15 -: TABLE_BITS];
		sin_quad = idx[TABLE_BITS-1 -: 2];
		cos_quad = sin_quad + 2'd1;
		r_ext = {1'b0, idx[TABLE_BITS-3:0]};
		sin_addr = sin_quad[0] ? (QUARTER_A - r_ext) : r_ext;
		cos_addr = cos_quad[0] ? (QUARTER_A - r_ext) : r_ext;
	end

	always_ff @(posedge clk) begin
		trig_s1.sin_mag <= rom_mem[sin_addr];
		trig_s1.cos_mag <= rom_mem[cos_addr];
		trig_s1.sin_neg <= sin_quad[1];
		trig_s1.cos_neg <= cos_quad[1];
	end

endmodule

// File: rtl/e2q_prod.sv
// two product stages: half-angle pair products, then the quaternion terms
// depends on e2q_pkg
module e2q_prod (
	input  logic            clk,
	input  e2q_pkg::trig_t  roll_s1,
	input  e2q_pkg::trig_t  pitch_s1,
	input  e2q_pkg::trig_t  yaw_s1,
	output e2q_pkg::prod_t  prod_s3
);

	logic signed [15:0] sr, cr, sp, cp, sy, cy;

	always_comb begin
		sr = e2q_pkg::to_q14(roll_s1.sin_neg, roll_s1.sin_mag);
		cr = e2q_pkg::to_q14(roll_s1.cos_neg, roll_s1.cos_mag);
		sp = e2q_pkg::to_q14(pitch_s1.sin_neg, pitch_s1.sin_mag);
		cp = e2q_pkg::to_q14(pitch_s1.cos_neg, pitch_s1.cos_mag);
		sy = e2q_pkg::to_q14(yaw_s1.sin_neg, yaw_s1.sin_mag);
		cy = e2q_pkg::to_q14(yaw_s1.cos_neg, yaw_s1.cos_mag);
	end

	logic signed [15:0] sr_s2, cr_s2, sy_s2, cy_s2;
	logic signed [15:0] cpy_s2, spy_s2, crsp_s2, srcp_s2, crcp_s2, srsp_s2;

	always_ff @(posedge clk) begin
		sr_s2   <= sr;
		cr_s2   <= cr;
		sy_s2   <= sy;
		cy_s2   <= cy;
		cpy_s2  <= e2q_pkg::mul14(cp, cy);
		spy_s2  <= e2q_pkg::mul14(sp, sy);
		crsp_s2 <= e2q_pkg::mul14(cr, sp);
		srcp_s2 <= e2q_pkg::mul14(sr, cp);
		crcp_s2 <= e2q_pkg::mul14(cr, cp);
		srsp_s2 <= e2q_pkg::mul14(sr, sp);
	end

	always_ff @(posedge clk) begin
		prod_s3.w_a <= e2q_pkg::mul14(cr_s2, cpy_s2);
		prod_s3.w_b <= e2q_pkg::mul14(sr_s2, spy_s2);
		prod_s3.x_a <= e2q_pkg::mul14(sr_s2, cpy_s2);
		prod_s3.x_b <= e2q_pkg::mul14(cr_s2, spy_s2);
		prod_s3.y_a <= e2q_pkg::mul14(cy_s2, crsp_s2);
		prod_s3.y_b <= e2q_pkg::mul14(sy_s2, srcp_s2);
		prod_s3.z_a <= e2q_pkg::mul14(sy_s2, crcp_s2);
		prod_s3.z_b <= e2q_pkg::mul14(cy_s2, srsp_s2);
	end

endmodule

// File: rtl/euler_to_quaternion_top.sv
// euler angle (zyx) to unit quaternion converter, top level
// depends on e2q_pkg, e2q_trig, e2q_prod and the assertion macro header
//
// usage:
//   drive roll, pitch and yaw on angles and raise start; a transaction is
//   taken at each rising edge with start high and busy low. busy stays low,
//   so a new angle triple can enter on every cycle.
//   each result appears on quat for exactly one cycle with done high and
//   must be captured then; the receiver cannot stall the block.
// pipeline: the accepted angles pass through registered stages in order
//   (rom read, pair products, quaternion products, sum and saturate).
// throughput: one transaction per cycle, set by the fully pipelined
//   multipliers and the two read ports of each angle's sine rom.
// reset: arst_n low clears the valid pipeline; no results are issued from
//   work in flight at reset. the sine rom is constant and needs no fill.
// TABLE_BITS sets the rom resolution: 2^(TABLE_BITS-2)+1 quarter-wave
//   entries per angle.
`include "euler_to_quaternion_top_defines.svh"

module euler_to_quaternion_top #(
	parameter int unsigned TABLE_BITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  e2q_pkg::angles_t  angles,
	output logic              busy,
	output logic              done,
	output e2q_pkg::quat_t    quat
);

	logic           accept;
	logic           valid_s1, valid_s2, valid_s3, valid_s4;
	e2q_pkg::trig_t roll_s1, pitch_s1, yaw_s1;
	e2q_pkg::prod_t prod_s3;
	e2q_pkg::quat_t quat_s4;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	e2q_trig #(.TABLE_BITS(TABLE_BITS)) u_trig_roll (
		.clk     (clk),
		.angle   (angles.roll_angle),
		.trig_s1 (roll_s1)
	);

	e2q_trig #(.TABLE_BITS(TABLE_BITS)) u_trig_pitch (
		.clk     (clk),
		.angle   (angles.pitch_angle),
		.trig_s1 (pitch_s1)
	);

	e2q_trig #(.TABLE_BITS(TABLE_BITS)) u_trig_yaw (
		.clk     (clk),
		.angle   (angles.yaw_angle),
		.trig_s1 (yaw_s1)
	);

	e2q_prod u_prod (
		.clk      (clk),
		.roll_s1  (roll_s1),
		.pitch_s1 (pitch_s1),
		.yaw_s1   (yaw_s1),
		.prod_s3  (prod_s3)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// sum and saturate
	always_ff @(posedge clk) begin
		quat_s4.quat_w <= e2q_pkg::sat_q14(17'(prod_s3.w_a) + 17'(prod_s3.w_b));
		quat_s4.quat_x <= e2q_pkg::sat_q14(17'(prod_s3.x_a) - 17'(prod_s3.x_b));
		quat_s4.quat_y <= e2q_pkg::sat_q14(17'(prod_s3.y_a) + 17'(prod_s3.y_b));
		quat_s4.quat_z <= e2q_pkg::sat_q14(17'(prod_s3.z_a) - 17'(prod_s3.z_b));
	end

	assign done = valid_s4;
	assign quat = quat_s4;

	`E2Q_ASSERT_IMPL(a_done_latency, done, $past(accept, 4), "result without a transaction 4 cycles earlier")
	`E2Q_ASSERT_NEXT(a_valid_flow, valid_s3, done, "valid lost between product and output stage")
	`E2Q_ASSERT_IMPL(a_wx_range, done, (quat.quat_w <= 16'sd16384) && (quat.quat_w >= -16'sd16384) && (quat.quat_x <= 16'sd16384) && (quat.quat_x >= -16'sd16384), "w or x out of q2.14 unit range")
	`E2Q_ASSERT_IMPL(a_yz_range, done, (quat.quat_y <= 16'sd16384) && (quat.quat_y >= -16'sd16384) && (quat.quat_z <= 16'sd16384) && (quat.quat_z >= -16'sd16384), "y or z out of q2.14 unit range")

endmodule
